### rtl/core/tgc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tgc_pkg
// Shared types and codes for the touch gesture classifier core.
// ----------------------------------------------------------------------------
package tgc_pkg;

   localparam int COORD_WIDTH = 12;
   localparam int CFG_INDEX_WIDTH = 2;
   localparam int CFG_DATA_WIDTH = 16;

   // action codes
   localparam logic [2:0] ACT_TICK  = 3'd0;
   localparam logic [2:0] ACT_BEGIN = 3'd1;
   localparam logic [2:0] ACT_MOVE  = 3'd2;
   localparam logic [2:0] ACT_END   = 3'd3;
   localparam logic [2:0] ACT_SET   = 3'd4;

   // gesture codes
   localparam logic [1:0] GS_NONE = 2'd0;
   localparam logic [1:0] GS_TAP  = 2'd1;
   localparam logic [1:0] GS_HOLD = 2'd2;
   localparam logic [1:0] GS_DRAG = 2'd3;

   // register indexes
   localparam logic [CFG_INDEX_WIDTH-1:0] REG_DRAG_DIST_SQ    = 2'd0;
   localparam logic [CFG_INDEX_WIDTH-1:0] REG_TAP_MAX_TICKS   = 2'd1;
   localparam logic [CFG_INDEX_WIDTH-1:0] REG_HOLD_IDLE_TICKS = 2'd2;
   localparam logic [CFG_INDEX_WIDTH-1:0] REG_CLEAR_TICKS     = 2'd3;

   typedef struct packed {
      logic [2:0]             action;
      logic [COORD_WIDTH-1:0] touch_x;
      logic [COORD_WIDTH-1:0] touch_y;
      logic [1:0]             new_state;
   } req_item_type;

   typedef struct packed {
      logic [1:0]             gesture;
      logic                   move_valid;
      logic [COORD_WIDTH-1:0] move_x;
      logic [COORD_WIDTH-1:0] move_y;
   } rsp_item_type;

   typedef struct packed {
      logic [15:0] drag_dist_sq;
      logic [7:0]  tap_max_ticks;
      logic [7:0]  hold_idle_ticks;
      logic [7:0]  clear_ticks;
   } cfg_type;

endpackage
`default_nettype wire

### rtl/core/tgc_csr.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tgc_csr
// Threshold registers written through the configuration channel.
// ----------------------------------------------------------------------------
module tgc_csr (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [tgc_pkg::CFG_INDEX_WIDTH-1:0]   csr_index,
   input  wire logic [tgc_pkg::CFG_DATA_WIDTH-1:0]    csr_data,
   output tgc_pkg::cfg_type                           cfg
);
   import tgc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_DRAG_DIST_SQ:    cfg_in.drag_dist_sq = csr_data;
            REG_TAP_MAX_TICKS:   cfg_in.tap_max_ticks = csr_data[7:0];
            REG_HOLD_IDLE_TICKS: cfg_in.hold_idle_ticks = csr_data[7:0];
            REG_CLEAR_TICKS:     cfg_in.clear_ticks = csr_data[7:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.drag_dist_sq <= 16'd9;
         cfg_ff.tap_max_ticks <= 8'd10;
         cfg_ff.hold_idle_ticks <= 8'd30;
         cfg_ff.clear_ticks <= 8'd60;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

### rtl/core/tgc_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tgc_engine
// Gesture state, counters and last point; computes the result of one item.
// ----------------------------------------------------------------------------
module tgc_engine #(
   parameter int COUNT_WIDTH = 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  fire,
   input  wire tgc_pkg::req_item_type item,
   input  wire tgc_pkg::cfg_type      cfg,
   output tgc_pkg::rsp_item_type      result
);
   import tgc_pkg::*;

   localparam int CMP_WIDTH = (COUNT_WIDTH > 8) ? COUNT_WIDTH : 8;
   localparam int SQ_WIDTH = 2 * COORD_WIDTH + 1;

   logic                   touched_ff, touched_in;
   logic [1:0]             gesture_ff, gesture_in;
   logic [COUNT_WIDTH-1:0] hold_ff, hold_in;
   logic [COUNT_WIDTH-1:0] idle_ff, idle_in;
   logic [COORD_WIDTH-1:0] last_x_ff, last_x_in;
   logic [COORD_WIDTH-1:0] last_y_ff, last_y_in;

   logic [COORD_WIDTH-1:0]   dx, dy;
   logic [2*COORD_WIDTH-1:0] dx_sq, dy_sq;
   logic [SQ_WIDTH-1:0]      dist_sq;
   logic                     far;
   logic [COUNT_WIDTH-1:0]   hold_inc, idle_inc;
   logic [CMP_WIDTH-1:0]     hold_inc_w, hold_w, idle_inc_w;
   logic [CMP_WIDTH-1:0]     tap_w, idle_lim_w, clear_w;
   logic                     mv;

   assign dx = (item.touch_x > last_x_ff) ? item.touch_x - last_x_ff
                                          : last_x_ff - item.touch_x;
   assign dy = (item.touch_y > last_y_ff) ? item.touch_y - last_y_ff
                                          : last_y_ff - item.touch_y;
   assign dx_sq = dx * dx;
   assign dy_sq = dy * dy;
   assign dist_sq = SQ_WIDTH'(dx_sq) + SQ_WIDTH'(dy_sq);
   assign far = dist_sq > SQ_WIDTH'(cfg.drag_dist_sq);

   assign hold_inc = (&hold_ff) ? hold_ff : hold_ff + 1'b1;
   assign idle_inc = (&idle_ff) ? idle_ff : idle_ff + 1'b1;
   assign hold_inc_w = CMP_WIDTH'(hold_inc);
   assign hold_w = CMP_WIDTH'(hold_ff);
   assign idle_inc_w = CMP_WIDTH'(idle_inc);
   assign tap_w = CMP_WIDTH'(cfg.tap_max_ticks);
   assign idle_lim_w = CMP_WIDTH'(cfg.hold_idle_ticks);
   assign clear_w = CMP_WIDTH'(cfg.clear_ticks);

   always_comb begin
      touched_in = touched_ff;
      gesture_in = gesture_ff;
      hold_in = hold_ff;
      idle_in = idle_ff;
      last_x_in = last_x_ff;
      last_y_in = last_y_ff;
      mv = 1'b0;
      unique case (item.action)
         ACT_TICK: begin
            hold_in = hold_inc;
            if (touched_ff) begin
               idle_in = idle_inc;
               if (hold_inc_w > tap_w && idle_inc_w > idle_lim_w) begin
                  gesture_in = GS_HOLD;
               end
            end else if (hold_inc_w > clear_w) begin
               gesture_in = GS_NONE;
            end
         end
         ACT_BEGIN: begin
            touched_in = 1'b1;
            hold_in = '0;
            gesture_in = GS_NONE;
            last_x_in = item.touch_x;
            last_y_in = item.touch_y;
         end
         ACT_MOVE: begin
            if (touched_ff) begin
               if (gesture_ff == GS_DRAG || far) begin
                  gesture_in = GS_DRAG;
                  idle_in = '0;
                  mv = 1'b1;
               end
               last_x_in = item.touch_x;
               last_y_in = item.touch_y;
            end
         end
         ACT_END: begin
            if (touched_ff) begin
               if (hold_w < tap_w) begin
                  gesture_in = GS_TAP;
               end
               hold_in = '0;
               touched_in = 1'b0;
               last_x_in = item.touch_x;
               last_y_in = item.touch_y;
            end
         end
         ACT_SET: begin
            gesture_in = item.new_state;
         end
         default: begin
            gesture_in = gesture_ff;
         end
      endcase
   end

   assign result.gesture = gesture_in;
   assign result.move_valid = mv;
   assign result.move_x = mv ? item.touch_x : '0;
   assign result.move_y = mv ? item.touch_y : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         touched_ff <= 1'b0;
         gesture_ff <= GS_NONE;
         hold_ff <= '0;
         idle_ff <= '0;
         last_x_ff <= '0;
         last_y_ff <= '0;
      end else if (fire) begin
         touched_ff <= touched_in;
         gesture_ff <= gesture_in;
         hold_ff <= hold_in;
         idle_ff <= idle_in;
         last_x_ff <= last_x_in;
         last_y_ff <= last_y_in;
      end
   end

endmodule
`default_nettype wire

### rtl/core/touch_gesture_classifier_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// touch_gesture_classifier_core
// Sorts single-touch events into none, tap, hold or drag.
//
// req_* carries one event item (tick, begin, move, end, set state); it is
// taken at an edge with req_valid high and req_stall low. Every item gives
// exactly one rsp_* item: the gesture after the event and, for a drag move,
// the touch point to move the object to.
// An item taken waits in the event register, is evaluated against the gesture
// state combinationally and is stored in the result register on rsp_item.
// Throughput: one item per cycle while rsp_stall is low. While rsp_stall is
// high and the result register is full, it holds and the event register
// keeps its item; req_stall rises only when both are full.
// csr_* writes the thresholds (index 0 drag distance squared, 1 tap ticks,
// 2 hold idle ticks, 3 clear ticks); csr_ready is always high.
// Reset (synchronous) clears the valid flags of both registers and the
// gesture state and loads the threshold defaults.
// ----------------------------------------------------------------------------
module touch_gesture_classifier_core #(
   parameter int COUNT_WIDTH = 8
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire tgc_pkg::req_item_type               req_item,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output tgc_pkg::rsp_item_type                    rsp_item,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [tgc_pkg::CFG_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [tgc_pkg::CFG_DATA_WIDTH-1:0]  csr_data
);
   import tgc_pkg::*;

   cfg_type      cfg;
   req_item_type evt_ff;
   logic         evt_valid_ff, evt_valid_in;
   rsp_item_type rsp_ff;
   rsp_item_type result;
   logic         rsp_valid_ff, rsp_valid_in;
   logic         advance;
   logic         take;

   assign advance = evt_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = evt_valid_ff && !advance;
   assign take = req_valid && !req_stall;
   assign evt_valid_in = take || (evt_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item = rsp_ff;

   tgc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   tgc_engine #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_engine (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (evt_ff),
      .cfg    (cfg),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         evt_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         evt_valid_ff <= evt_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         evt_ff <= req_item;
      end
      if (advance) begin
         rsp_ff <= result;
      end
   end

endmodule
`default_nettype wire
